@@ hw/rtl/matrix_diagonal_sorter_defines.svh @@
// Assertion macros shared by the diagonal sorter checkers
`ifndef MATRIX_DIAGONAL_SORTER_DEFINES_SVH
`define MATRIX_DIAGONAL_SORTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define MDS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mds check failed");

// Next-cycle implication, sampled on clk, off during reset
`define MDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mds check failed");

`endif

@@ hw/rtl/mds_pkg.sv @@
// Shared types for the matrix diagonal sorter
package mds_pkg;

    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 4'd1;

    typedef struct packed {
        logic shift;    // unload: every cell takes its right neighbor's word
    } cell_ctrl_t;

endpackage

@@ hw/rtl/mds_cell.sv @@
// One insertion cell: keeps the smaller key, hands the larger one right
module mds_cell
    import mds_pkg::*;
#(
    parameter int DGW = 4,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cell_ctrl_t            ctrl,
    input  logic                  in_valid,
    input  logic [DGW-1:0]        in_diag,
    input  logic [DATA_WIDTH-1:0] in_value,
    input  logic                  nb_valid,
    input  logic [DGW-1:0]        nb_diag,
    input  logic [DATA_WIDTH-1:0] nb_value,
    output logic                  held_valid,
    output logic [DGW-1:0]        held_diag,
    output logic [DATA_WIDTH-1:0] held_value,
    output logic                  pass_valid,
    output logic [DGW-1:0]        pass_diag,
    output logic [DATA_WIDTH-1:0] pass_value
);

    logic                  hv_reg, hv_next, pv_reg, pv_next;
    logic [DGW-1:0]        hd_reg, hd_next, pd_reg, pd_next;
    logic [DATA_WIDTH-1:0] hval_reg, hval_next, pval_reg, pval_next;
    logic [DGW+DATA_WIDTH-1:0] in_key, held_key;

    // flip the sign bit so unsigned order is signed order
    assign in_key   = {in_diag, ~in_value[DATA_WIDTH-1], in_value[DATA_WIDTH-2:0]};
    assign held_key = {hd_reg, ~hval_reg[DATA_WIDTH-1], hval_reg[DATA_WIDTH-2:0]};

    always_comb
    begin
        hv_next   = hv_reg;
        hd_next   = hd_reg;
        hval_next = hval_reg;
        pv_next   = 1'b0;
        pd_next   = pd_reg;
        pval_next = pval_reg;
        if (ctrl.shift)
        begin
            hv_next   = nb_valid;
            hd_next   = nb_diag;
            hval_next = nb_value;
        end
        else if (in_valid)
        begin
            if (!hv_reg)
            begin
                hv_next   = 1'b1;
                hd_next   = in_diag;
                hval_next = in_value;
            end
            else if (in_key < held_key)
            begin
                hd_next   = in_diag;
                hval_next = in_value;
                pv_next   = 1'b1;
                pd_next   = hd_reg;
                pval_next = hval_reg;
            end
            else
            begin
                pv_next   = 1'b1;
                pd_next   = in_diag;
                pval_next = in_value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg <= 1'b0;
            pv_reg <= 1'b0;
        end
        else
        begin
            hv_reg <= hv_next;
            pv_reg <= pv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hd_reg   <= hd_next;
        hval_reg <= hval_next;
        pd_reg   <= pd_next;
        pval_reg <= pval_next;
    end

    assign held_valid = hv_reg;
    assign held_diag  = hd_reg;
    assign held_value = hval_reg;
    assign pass_valid = pv_reg;
    assign pass_diag  = pd_reg;
    assign pass_value = pval_reg;

endmodule

@@ hw/rtl/matrix_diagonal_sorter.sv @@
// Top level: load, systolic diagonal sort, unload to memory, emit row-major
//
//  channel   dir  handshake          payload
//  input     in   in_valid/in_stall  element_value
//  output    out  out_valid/out_stall sorted_value, final_element
//  config    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// Load takes one word per cycle into a buffer; in_stall is high outside the load phase.
// Once rows*cols words are in, the buffer feeds the cell chain one word per cycle, the
// chain settles, then unloads into the diagonal memory; emit issues the next read
// only after the held word has left the issue/hold step on the registered read.
// Reset clears control state only; output stalls hold the word and pause emit.
module matrix_diagonal_sorter
    import mds_pkg::*;
#(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8,
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] element_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] sorted_value,
    output logic                         final_element,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_W-1:0]             cfg_data
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int DIAGS = MAX_ROWS + MAX_COLS - 1;
    localparam int DGW   = (DIAGS > 1) ? $clog2(DIAGS) : 1;
    localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int PW    = (MAXD > 1) ? $clog2(MAXD) : 1;
    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCW   = RIW + 1;
    localparam int CCW   = CIW + 1;
    localparam int AW    = DGW + PW;
    localparam int STW   = $clog2(CELLS + 2);
    localparam int EW    = DGW + RIW + CIW + 1;
    localparam int LW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNTW  = $clog2(CELLS + 1);

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_FEED   = 3'd1;
    localparam logic [2:0] ST_SETTLE = 3'd2;
    localparam logic [2:0] ST_UNLOAD = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CFG_W-1:0] row_count_reg, col_count_reg;
    logic [RCW-1:0]   rows_eff;
    logic [CCW-1:0]   cols_eff;
    logic [RIW-1:0]   row_last, row_last_reg, row_last_next;
    logic [CIW-1:0]   col_last, col_last_reg, col_last_next;
    logic [CNTW-1:0]  total, ld_cnt_reg, ld_cnt_next;
    logic [LW-1:0]    fd_k_reg, fd_k_next;
    logic             fv_reg, fv_next;
    logic [DGW-1:0]   fdiag_reg;
    logic [DATA_WIDTH-1:0] raw_q_reg;
    logic [DATA_WIDTH-1:0] raw_mem [0:CELLS-1];

    logic [RIW-1:0]   ld_r_reg, ld_r_next, em_r_reg, em_r_next;
    logic [CIW-1:0]   ld_c_reg, ld_c_next, em_c_reg, em_c_next;
    logic [STW-1:0]   settle_reg, settle_next;
    logic [DGW-1:0]   prev_diag_reg, prev_diag_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic             first_reg, first_next;
    logic             pend_reg, pend_next, emit_done_reg, emit_done_next;
    logic             final_q_reg;
    logic             out_valid_reg, out_valid_next, out_final_reg;
    logic [DATA_WIDTH-1:0] mem_q_reg, out_data_reg;
    logic [DATA_WIDTH-1:0] mem [0:(1<<AW)-1];

    logic             accept, complete, feed, issue, move, em_last, ld_last, wr_en;
    logic [DGW-1:0]   ld_diag, em_diag;
    logic [PW-1:0]    em_pos, wr_pos;
    logic [AW-1:0]    wr_addr, rd_addr;
    cell_ctrl_t       ctrl;

    logic                  c_in_valid [CELLS];
    logic [DGW-1:0]        c_in_diag  [CELLS];
    logic [DATA_WIDTH-1:0] c_in_value [CELLS];
    logic                  c_nb_valid [CELLS];
    logic [DGW-1:0]        c_nb_diag  [CELLS];
    logic [DATA_WIDTH-1:0] c_nb_value [CELLS];
    logic                  h_valid    [CELLS];
    logic [DGW-1:0]        h_diag     [CELLS];
    logic [DATA_WIDTH-1:0] h_value    [CELLS];
    logic                  p_valid    [CELLS];
    logic [DGW-1:0]        p_diag     [CELLS];
    logic [DATA_WIDTH-1:0] p_value    [CELLS];

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= CFG_W'(8);
            col_count_reg <= CFG_W'(8);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_ROW_COUNT)
                row_count_reg <= cfg_data;
            else if (cfg_index == REG_COL_COUNT)
                col_count_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (row_count_reg == '0)
            rows_eff = RCW'(1);
        else if (row_count_reg > CFG_W'(MAX_ROWS))
            rows_eff = RCW'(MAX_ROWS);
        else
            rows_eff = RCW'(row_count_reg);
        if (col_count_reg == '0)
            cols_eff = CCW'(1);
        else if (col_count_reg > CFG_W'(MAX_COLS))
            cols_eff = CCW'(MAX_COLS);
        else
            cols_eff = CCW'(col_count_reg);
    end

    assign row_last = RIW'(rows_eff - RCW'(1));
    assign col_last = CIW'(cols_eff - CCW'(1));
    assign total    = CNTW'(rows_eff) * CNTW'(cols_eff);

    // diagonal index: col - row + rows - 1, with the size taken at completion
    assign ld_diag = DGW'(EW'(ld_c_reg) + EW'(row_last_reg) - EW'(ld_r_reg));
    assign em_diag = DGW'(EW'(em_c_reg) + EW'(row_last_reg) - EW'(em_r_reg));
    assign em_pos  = (EW'(em_r_reg) < EW'(em_c_reg)) ? PW'(em_r_reg) : PW'(em_c_reg);

    assign in_stall = (state_reg != ST_LOAD);
    assign accept   = in_valid && !in_stall;
    // size registers are read at every word; complete once the count reaches the size
    assign complete = accept && ((ld_cnt_reg + CNTW'(1)) >= total);
    assign feed     = (state_reg == ST_FEED);
    assign ld_last  = (ld_r_reg == row_last_reg) && (ld_c_reg == col_last_reg);
    assign em_last  = (em_r_reg == row_last_reg) && (em_c_reg == col_last_reg);
    assign ctrl.shift = (state_reg == ST_UNLOAD);

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < CELLS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign c_in_valid[gi] = fv_reg;
                assign c_in_diag[gi]  = fdiag_reg;
                assign c_in_value[gi] = raw_q_reg;
            end
            else
            begin : g_body
                assign c_in_valid[gi] = p_valid[gi-1];
                assign c_in_diag[gi]  = p_diag[gi-1];
                assign c_in_value[gi] = p_value[gi-1];
            end
            if (gi == CELLS - 1)
            begin : g_tail
                assign c_nb_valid[gi] = 1'b0;
                assign c_nb_diag[gi]  = '0;
                assign c_nb_value[gi] = '0;
            end
            else
            begin : g_link
                assign c_nb_valid[gi] = h_valid[gi+1];
                assign c_nb_diag[gi]  = h_diag[gi+1];
                assign c_nb_value[gi] = h_value[gi+1];
            end
            mds_cell #(
                .DGW        (DGW),
                .DATA_WIDTH (DATA_WIDTH)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .in_valid   (c_in_valid[gi]),
                .in_diag    (c_in_diag[gi]),
                .in_value   (c_in_value[gi]),
                .nb_valid   (c_nb_valid[gi]),
                .nb_diag    (c_nb_diag[gi]),
                .nb_value   (c_nb_value[gi]),
                .held_valid (h_valid[gi]),
                .held_diag  (h_diag[gi]),
                .held_value (h_value[gi]),
                .pass_valid (p_valid[gi]),
                .pass_diag  (p_diag[gi]),
                .pass_value (p_value[gi])
            );
        end
    endgenerate

    // unload: cell 0 comes out sorted by diagonal, then value
    assign wr_en   = (state_reg == ST_UNLOAD) && h_valid[0];
    assign wr_pos  = (first_reg || (h_diag[0] != prev_diag_reg)) ? '0 : pos_reg;
    assign wr_addr = {h_diag[0], wr_pos};
    assign rd_addr = {em_diag, em_pos};

    assign issue = (state_reg == ST_EMIT) && !pend_reg && !emit_done_reg;
    assign move  = pend_reg && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next     = state_reg;
        row_last_next  = row_last_reg;
        col_last_next  = col_last_reg;
        ld_cnt_next    = ld_cnt_reg;
        fd_k_next      = fd_k_reg;
        fv_next        = feed;
        ld_r_next      = ld_r_reg;
        ld_c_next      = ld_c_reg;
        em_r_next      = em_r_reg;
        em_c_next      = em_c_reg;
        settle_next    = settle_reg;
        prev_diag_next = prev_diag_reg;
        pos_next       = pos_reg;
        first_next     = first_reg;
        pend_next      = pend_reg;
        emit_done_next = emit_done_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (move)
            out_valid_next = 1'b1;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                    ld_cnt_next = ld_cnt_reg + CNTW'(1);
                if (complete)
                begin
                    ld_cnt_next   = '0;
                    row_last_next = row_last;
                    col_last_next = col_last;
                    fd_k_next     = '0;
                    ld_r_next     = '0;
                    ld_c_next     = '0;
                    state_next    = ST_FEED;
                end
            end
            ST_FEED:
            begin
                fd_k_next = fd_k_reg + LW'(1);
                if (ld_c_reg == col_last_reg)
                begin
                    ld_c_next = '0;
                    ld_r_next = ld_last ? '0 : ld_r_reg + RIW'(1);
                end
                else
                    ld_c_next = ld_c_reg + CIW'(1);
                if (ld_last)
                begin
                    state_next  = ST_SETTLE;
                    settle_next = '0;
                end
            end
            ST_SETTLE:
            begin
                settle_next = settle_reg + STW'(1);
                if (settle_reg == STW'(CELLS))
                begin
                    state_next = ST_UNLOAD;
                    first_next = 1'b1;
                end
            end
            ST_UNLOAD:
            begin
                if (wr_en)
                begin
                    first_next     = 1'b0;
                    prev_diag_next = h_diag[0];
                    pos_next       = wr_pos + PW'(1);
                end
                else
                begin
                    state_next     = ST_EMIT;
                    em_r_next      = '0;
                    em_c_next      = '0;
                    emit_done_next = 1'b0;
                end
            end
            ST_EMIT:
            begin
                if (issue)
                begin
                    pend_next = 1'b1;
                    if (em_last)
                        emit_done_next = 1'b1;
                    if (em_c_reg == col_last_reg)
                    begin
                        em_c_next = '0;
                        em_r_next = em_r_reg + RIW'(1);
                    end
                    else
                        em_c_next = em_c_reg + CIW'(1);
                end
                if (move && final_q_reg)
                    state_next = ST_LOAD;
            end
            default: state_next = ST_LOAD;
        endcase
        if (move)
            pend_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            row_last_reg  <= '0;
            col_last_reg  <= '0;
            ld_cnt_reg    <= '0;
            fd_k_reg      <= '0;
            fv_reg        <= 1'b0;
            ld_r_reg      <= '0;
            ld_c_reg      <= '0;
            em_r_reg      <= '0;
            em_c_reg      <= '0;
            settle_reg    <= '0;
            prev_diag_reg <= '0;
            pos_reg       <= '0;
            first_reg     <= 1'b1;
            pend_reg      <= 1'b0;
            emit_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_last_reg  <= row_last_next;
            col_last_reg  <= col_last_next;
            ld_cnt_reg    <= ld_cnt_next;
            fd_k_reg      <= fd_k_next;
            fv_reg        <= fv_next;
            ld_r_reg      <= ld_r_next;
            ld_c_reg      <= ld_c_next;
            em_r_reg      <= em_r_next;
            em_c_reg      <= em_c_next;
            settle_reg    <= settle_next;
            prev_diag_reg <= prev_diag_next;
            pos_reg       <= pos_next;
            first_reg     <= first_next;
            pend_reg      <= pend_next;
            emit_done_reg <= emit_done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // word k of the matrix lands in buffer entry k
    always_ff @(posedge clk)
    begin
        if (accept)
            raw_mem[ld_cnt_reg[LW-1:0]] <= element_value;
        if (feed)
        begin
            raw_q_reg <= raw_mem[fd_k_reg];
            fdiag_reg <= ld_diag;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= h_value[0];
        if (issue)
        begin
            mem_q_reg   <= mem[rd_addr];
            final_q_reg <= em_last;
        end
        if (move)
        begin
            out_data_reg  <= mem_q_reg;
            out_final_reg <= final_q_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sorted_value  = out_data_reg;
    assign final_element = out_final_reg;

endmodule

@@ hw/rtl/mds_checker.sv @@
// Port-level checker for the matrix diagonal sorter, bound to the top level
`include "matrix_diagonal_sorter_defines.svh"

module mds_checker
    import mds_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input logic [DATA_WIDTH-1:0] sorted_value,
    input logic                  final_element,
    input logic                  cfg_valid,
    input logic                  cfg_ready
);

    // a stalled word holds
    `MDS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sorted_value))
    // mid-matrix words only come out while input is stalled
    `MDS_ASSERT_SAME(a_emit_blocks_load, out_valid && !final_element, in_stall)
    // no word is accepted once an emitted matrix is partly out
    `MDS_ASSERT_SAME(a_load_clean, in_valid && !in_stall, !out_valid || final_element)
    // config writes are never held off
    `MDS_ASSERT_SAME(a_cfg_ready, cfg_valid, cfg_ready)

endmodule

bind matrix_diagonal_sorter mds_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_mds_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sorted_value  (sorted_value),
    .final_element (final_element),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready)
);

@@ bench/tb_matrix_diagonal_sorter.sv @@
// Testbench for the matrix diagonal sorter: random matrices, diagonal-sort predictor, scoreboard
`timescale 1ns / 100ps

module tb_matrix_diagonal_sorter
    import mds_pkg::*;
();

    localparam int MAX_ROWS    = 8;
    localparam int MAX_COLS    = 8;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [31:0] value;
        logic               last;
    } sorted_word_t;

    class diag_scoreboard;
        int                 row_reg = 8;
        int                 col_reg = 8;
        logic signed [31:0] loaded[$];
        sorted_word_t       sorted_words[$];
        int                 mismatches = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == REG_ROW_COUNT)
                row_reg = int'(data);
            else if (idx == REG_COL_COUNT)
                col_reg = int'(data);
        endfunction

        function int clamp(int v, int maxv);
            if (v == 0)
                return 1;
            if (v > maxv)
                return maxv;
            return v;
        endfunction

        // Take one accepted word; on the last one sort every diagonal and queue the matrix.
        function void note_element(logic signed [31:0] v);
            int                 rows;
            int                 cols;
            int                 n;
            int                 r;
            int                 c;
            int                 b;
            logic signed [31:0] grid[64];
            logic signed [31:0] diag[16];
            logic signed [31:0] x;
            sorted_word_t       w;
            rows = clamp(row_reg, MAX_ROWS);
            cols = clamp(col_reg, MAX_COLS);
            loaded = {loaded, v};
            if (loaded.size() < rows * cols)
                return;
            for (int k = 0; k < rows * cols; k++)
                grid[k] = loaded[k];
            for (int s = 0; s < rows + cols - 1; s++)
            begin
                r = (s < cols) ? 0 : s - cols + 1;
                c = (s < cols) ? s : 0;
                n = 0;
                while (r + n < rows && c + n < cols)
                begin
                    x = grid[(r + n) * cols + c + n];
                    b = n;
                    while (b > 0 && diag[b - 1] > x)
                    begin
                        diag[b] = diag[b - 1];
                        b--;
                    end
                    diag[b] = x;
                    n++;
                end
                for (int a = 0; a < n; a++)
                    grid[(r + a) * cols + c + a] = diag[a];
            end
            for (int k = 0; k < rows * cols; k++)
            begin
                w.value = grid[k];
                w.last  = (k == rows * cols - 1);
                sorted_words = {sorted_words, w};
            end
            loaded.delete();
        endfunction

        function void check_word(logic signed [31:0] v, logic fin);
            sorted_word_t w;
            if (sorted_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: value %0d last %0b", v, fin);
                return;
            end
            w = sorted_words.pop_front();
            if (w.value !== v || w.last !== fin)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                             w.value, w.last, v, fin);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [31:0]   element_value;
    logic                 out_valid;
    logic                 out_stall;
    logic signed [31:0]   sorted_value;
    logic                 final_element;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    diag_scoreboard sb = new();
    int             send_idle_pct = 0;
    int             recv_idle_pct = 0;
    int             hold_off = 0;
    int             sent_count = 0;
    int             cycle_count = 0;

    matrix_diagonal_sorter dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .element_value(element_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sorted_value(sorted_value),
        .final_element(final_element),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Receiver: check each accepted word, then pick the stall for the next cycle.
    initial
    begin
        out_stall = 1'b1;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_word(sorted_value, final_element);
            if (hold_off > 0)
            begin
                hold_off--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    task automatic send_word(logic signed [31:0] v);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid      <= 1'b1;
        element_value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_element(v);
        sent_count++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid and wait until every queued word has come out.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.sorted_words.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_size(int rows, int cols);
        write_reg(REG_ROW_COUNT, CFG_W'(rows));
        write_reg(REG_COL_COUNT, CFG_W'(cols));
    endtask

    function automatic logic signed [31:0] rand_value();
        case ($urandom_range(7))
            0: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            1, 2: return $signed($urandom_range(8)) - 4;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_matrix();
        int n;
        n = sb.clamp(sb.row_reg, MAX_ROWS) * sb.clamp(sb.col_reg, MAX_COLS);
        for (int k = 0; k < n; k++)
            send_word(rand_value());
    endtask

    initial
    begin
        int phase;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        element_value = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero sizes, signed extremes, duplicates, oversize columns.
        set_size(0, 0);
        send_word(32'sh80000000);
        send_word(32'sh7fffffff);
        drain();
        set_size(2, 3);
        send_word(32'sh7fffffff);
        send_word(-1);
        send_word(0);
        send_word(32'sh80000000);
        send_word(-1);
        send_word(32'sh7fffffff);
        drain();
        set_size(3, 2);
        send_word(5);
        send_word(5);
        send_word(32'sh80000000);
        send_word(-5);
        send_word(-5);
        send_word(1);
        drain();
        set_size(1, 15);
        for (int k = 0; k < 8; k++)
            send_word(32'sh55555555 ^ (k << 28));
        drain();

        phase = 0;
        while (sent_count < 170)
        begin
            case (phase % 3)
                0:
                begin
                    send_idle_pct = 25;
                    recv_idle_pct = 88;
                end
                1:
                begin
                    send_idle_pct = 88;
                    recv_idle_pct = 25;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (phase == 2)
                set_size(15, 8);
            else if ($urandom_range(5) == 0)
                set_size($urandom_range(15), $urandom_range(15) % 3);
            else
                set_size($urandom_range(4, 1), $urandom_range(4, 1));
            // Long receiver hold-off while the sender keeps offering.
            if (phase == 3)
                hold_off = 400;
            send_matrix();
            if (phase != 2)
                send_matrix();
            drain();
            phase++;
        end

        drain();
        if (sb.mismatches == 0 && sb.sorted_words.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
